@@ hdl/mi3_pkg.sv @@
package mi3_pkg;

    // Default number formats: Q16.16 in a 32-bit word.
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Adjugate entry k = a[p]*a[q] - a[r]*a[s], entries indexed row*3+col.
    localparam int ADJ_TAB [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // Status of the queue between the front and back halves.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ hdl/mi3_front.sv @@
module mi3_front #(
    parameter int W = mi3_pkg::WORD_BITS_DEF,
    parameter int F = mi3_pkg::FRAC_BITS_DEF,
    localparam int PW = 9 * (2 * W + 1) + 4 * W + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [W-1:0]        in_ent [9],
    output logic                push,
    output logic [PW-1:0]       push_data
);

    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 2;
    localparam int MW = 3 * W;
    localparam int CB = 9 * AW;

    logic [4:0]              v_reg;
    logic signed [W-1:0]     a_reg [9];
    logic signed [2*W-1:0]   pp_reg [9];
    logic signed [2*W-1:0]   pq_reg [9];
    logic signed [W-1:0]     r1_reg [3];
    logic signed [W-1:0]     r2_reg [3];
    logic signed [AW-1:0]    adj_reg [9];
    logic signed [AW-1:0]    adj3_reg [9];
    logic signed [AW-1:0]    adj4_reg [9];
    logic signed [AW-1:0]    plo_reg [3];
    logic signed [AW-1:0]    phi_reg [3];
    logic signed [DW-1:0]    det_reg;

    logic signed [W:0]       adj_lo [3];
    logic signed [W:0]       adj_hi [3];
    logic signed [DW-1:0]    det_next;
    logic                    dneg;
    logic [MW-1:0]           dmag;
    logic [MW:0]             rnd;
    logic [MW:0]             lim;
    logic [MW:0]             sat;
    logic [W-1:0]            det_out;
    logic [2*W-1:0]          cmag [9];

    // Valid bits of the front pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // Stage one: capture the matrix.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            for (int i = 0; i < 9; i++)
            begin
                a_reg[i] <= in_ent[i];
            end
        end
    end

    // Stage two: the eighteen cofactor products.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            pp_reg[k] <= a_reg[mi3_pkg::ADJ_TAB[k][0]] * a_reg[mi3_pkg::ADJ_TAB[k][1]];
            pq_reg[k] <= a_reg[mi3_pkg::ADJ_TAB[k][2]] * a_reg[mi3_pkg::ADJ_TAB[k][3]];
        end
        for (int j = 0; j < 3; j++)
        begin
            r1_reg[j] <= a_reg[j];
        end
    end

    // Stage three: adjugate entries.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            adj_reg[k] <= AW'(pp_reg[k]) - AW'(pq_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            r2_reg[j] <= r1_reg[j];
        end
    end

    // Stage four: row 0 times the first adjugate column, split into two halves.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            adj_lo[j] = $signed({1'b0, adj_reg[3 * j][W-1:0]});
            adj_hi[j] = adj_reg[3 * j][AW-1:W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            plo_reg[j] <= r2_reg[j] * adj_lo[j];
            phi_reg[j] <= r2_reg[j] * adj_hi[j];
        end
        for (int k = 0; k < 9; k++)
        begin
            adj3_reg[k] <= adj_reg[k];
        end
    end

    // Stage five: exact determinant.
    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(phi_reg[j]) <<< W) + DW'(plo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
        for (int k = 0; k < 9; k++)
        begin
            adj4_reg[k] <= adj3_reg[k];
        end
    end

    // Classify and take magnitudes; round and saturate the determinant.
    always_comb
    begin
        dneg    = det_reg[DW-1];
        dmag    = dneg ? MW'(-det_reg) : MW'(det_reg);
        rnd     = ({1'b0, dmag} + ((MW+1)'(1) << (2 * F - 1))) >> (2 * F);
        lim     = ((MW+1)'(1) << (W - 1)) - (MW+1)'(!dneg);
        sat     = (rnd > lim) ? lim : rnd;
        det_out = dneg ? W'(-sat) : W'(sat);
        for (int k = 0; k < 9; k++)
        begin
            cmag[k] = adj4_reg[k][AW-1] ? (2*W)'(-adj4_reg[k]) : (2*W)'(adj4_reg[k]);
            push_data[k*AW +: AW] = {adj4_reg[k][AW-1], cmag[k]};
        end
        push_data[CB +: MW]          = dmag;
        push_data[CB + MW]           = dneg;
        push_data[CB + MW + 1 +: W]  = det_out;
        push_data[CB + MW + W + 1]   = (det_reg == '0);
    end

    assign push = v_reg[4];

endmodule

@@ hdl/mi3_queue.sv @@
module mi3_queue #(
    parameter int PW = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [PW-1:0]     push_data,
    input  logic              pop,
    output logic [PW-1:0]     pop_data,
    output mi3_pkg::q_stat_t  stat
);

    logic [PW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

@@ hdl/mi3_back.sv @@
module mi3_back #(
    parameter int W = mi3_pkg::WORD_BITS_DEF,
    parameter int F = mi3_pkg::FRAC_BITS_DEF,
    localparam int PW = 9 * (2 * W + 1) + 4 * W + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mi3_pkg::q_stat_t    q_stat,
    input  logic [PW-1:0]       q_data,
    output logic                pop,
    output logic [W-1:0]        inv [9],
    output logic [W-1:0]        det_value,
    output logic                singular,
    output logic                done
);

    localparam int AW   = 2 * W + 1;
    localparam int MW   = 3 * W;
    localparam int CB   = 9 * AW;
    localparam int NUMW = 2 * W + 2 * F + 2;
    localparam int DENW = 4 * W + 2;
    localparam int XW   = ((NUMW > DENW) ? NUMW : DENW) + 1;
    localparam int NS   = W + 1;

    logic [NS:0]        v_reg;
    logic [XW-1:0]      rem_reg [NS+1][9];
    logic [W:0]         q_reg [NS+1][9];
    logic               neg_reg [NS+1][9];
    logic               ov_reg [NS+1][9];
    logic [XW-1:0]      den_reg [NS+1];
    logic [W-1:0]       dout_reg [NS+1];
    logic               sing_reg [NS+1];

    logic [W-1:0]       inv_reg [9];
    logic [W-1:0]       det_reg;
    logic               singular_reg;
    logic               done_reg;

    logic [XW-1:0]      num [9];
    logic [XW-1:0]      den;
    logic               dneg;

    assign pop = !q_stat.empty;

    // Valid bits of the divider pipeline and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[NS-1:0], pop};
            done_reg <= v_reg[NS];
        end
    end

    // Numerator 2*|C|*2^(2F) + |D| over denominator 2*|D| rounds to nearest.
    always_comb
    begin
        den  = XW'(q_data[CB +: MW]) << 1;
        dneg = q_data[CB + MW];
        for (int k = 0; k < 9; k++)
        begin
            num[k] = (XW'(q_data[k*AW +: 2*W]) << (2 * F + 1)) + XW'(q_data[CB +: MW]);
        end
    end

    // Entry stage: take the item from the queue and flag quotients past W+1 bits.
    always_ff @(posedge clk)
    begin
        den_reg[0]  <= den;
        dout_reg[0] <= q_data[CB + MW + 1 +: W];
        sing_reg[0] <= q_data[CB + MW + W + 1];
        for (int k = 0; k < 9; k++)
        begin
            rem_reg[0][k] <= num[k];
            q_reg[0][k]   <= '0;
            neg_reg[0][k] <= q_data[k*AW + AW - 1] ^ dneg;
            ov_reg[0][k]  <= (num[k] >= (den << (W + 1)));
        end
    end

    // Restoring division, one quotient bit per stage for each of nine lanes.
    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        localparam int B = NS - s;
        logic [XW-1:0] sh;
        logic          ge [9];

        assign sh = den_reg[s-1] << B;

        always_comb
        begin
            for (int k = 0; k < 9; k++)
            begin
                ge[k] = (rem_reg[s-1][k] >= sh);
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s]  <= den_reg[s-1];
            dout_reg[s] <= dout_reg[s-1];
            sing_reg[s] <= sing_reg[s-1];
            for (int k = 0; k < 9; k++)
            begin
                rem_reg[s][k] <= ge[k] ? (rem_reg[s-1][k] - sh) : rem_reg[s-1][k];
                q_reg[s][k]   <= {q_reg[s-1][k][W-1:0], ge[k]};
                neg_reg[s][k] <= neg_reg[s-1][k];
                ov_reg[s][k]  <= ov_reg[s-1][k];
            end
        end
    end

    // Saturate, apply the sign and force zero for a singular matrix.
    always_ff @(posedge clk)
    begin
        logic [W:0] lim;
        logic [W:0] mag;
        for (int k = 0; k < 9; k++)
        begin
            lim = ((W+1)'(1) << (W - 1)) - (W+1)'(!neg_reg[NS][k]);
            mag = (ov_reg[NS][k] || (q_reg[NS][k] > lim)) ? lim : q_reg[NS][k];
            if (sing_reg[NS])
            begin
                inv_reg[k] <= '0;
            end
            else
            begin
                inv_reg[k] <= neg_reg[NS][k] ? W'(-mag) : W'(mag);
            end
        end
        det_reg      <= dout_reg[NS];
        singular_reg <= sing_reg[NS];
    end

    assign inv       = inv_reg;
    assign det_value = det_reg;
    assign singular  = singular_reg;
    assign done      = done_reg;

endmodule

@@ hdl/matrix3x3_inverse_top.sv @@
// 3x3 matrix inverse by the adjugate method, signed fixed point
// (WORD_BITS wide, FRAC_BITS fraction bits; Q16.16 by default).
// Input: drive the nine entries and raise start; an item is taken at
// each rising edge with start high and busy low. A new matrix can be
// given every cycle.
// Output: done is high for exactly one cycle with the nine inverse
// entries, det_value and singular; the receiver cannot hold it off.
// Throughput is one item per cycle: five front stages form the exact
// determinant and adjugate, a two-entry queue follows, and the back end
// runs an entry stage, nine restoring dividers of WORD_BITS + 1 stages,
// one quotient bit each, and an output register that drives done.
// busy rises only if the queue is full, which does not happen since the
// back end drains it every cycle.
// A zero determinant gives singular = 1 and all outputs zero; other
// values round to nearest, ties away from zero, and saturate.
// Reset clears all valid bits; items in flight are dropped.
module matrix3x3_inverse_top #(
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] in_r0c0,
    input  logic [WORD_BITS-1:0] in_r0c1,
    input  logic [WORD_BITS-1:0] in_r0c2,
    input  logic [WORD_BITS-1:0] in_r1c0,
    input  logic [WORD_BITS-1:0] in_r1c1,
    input  logic [WORD_BITS-1:0] in_r1c2,
    input  logic [WORD_BITS-1:0] in_r2c0,
    input  logic [WORD_BITS-1:0] in_r2c1,
    input  logic [WORD_BITS-1:0] in_r2c2,
    output logic                 done,
    output logic [WORD_BITS-1:0] inv_r0c0,
    output logic [WORD_BITS-1:0] inv_r0c1,
    output logic [WORD_BITS-1:0] inv_r0c2,
    output logic [WORD_BITS-1:0] inv_r1c0,
    output logic [WORD_BITS-1:0] inv_r1c1,
    output logic [WORD_BITS-1:0] inv_r1c2,
    output logic [WORD_BITS-1:0] inv_r2c0,
    output logic [WORD_BITS-1:0] inv_r2c1,
    output logic [WORD_BITS-1:0] inv_r2c2,
    output logic [WORD_BITS-1:0] det_value,
    output logic                 singular
);

    localparam int PW = 9 * (2 * WORD_BITS + 1) + 4 * WORD_BITS + 2;

    logic [WORD_BITS-1:0] ent [9];
    logic [WORD_BITS-1:0] inv [9];
    logic                 push;
    logic [PW-1:0]        push_data;
    logic                 pop;
    logic [PW-1:0]        pop_data;
    mi3_pkg::q_stat_t     q_stat;

    assign busy = q_stat.full;

    assign ent[0] = in_r0c0;
    assign ent[1] = in_r0c1;
    assign ent[2] = in_r0c2;
    assign ent[3] = in_r1c0;
    assign ent[4] = in_r1c1;
    assign ent[5] = in_r1c2;
    assign ent[6] = in_r2c0;
    assign ent[7] = in_r2c1;
    assign ent[8] = in_r2c2;

    // Front: determinant, adjugate and classification.
    mi3_front #(.W(WORD_BITS), .F(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_ent    (ent),
        .push      (push),
        .push_data (push_data)
    );

    mi3_queue #(.PW(PW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Back: division of each adjugate entry by the determinant.
    mi3_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (pop_data),
        .pop       (pop),
        .inv       (inv),
        .det_value (det_value),
        .singular  (singular),
        .done      (done)
    );

    assign inv_r0c0 = inv[0];
    assign inv_r0c1 = inv[1];
    assign inv_r0c2 = inv[2];
    assign inv_r1c0 = inv[3];
    assign inv_r1c1 = inv[4];
    assign inv_r1c2 = inv[5];
    assign inv_r2c0 = inv[6];
    assign inv_r2c1 = inv[7];
    assign inv_r2c2 = inv[8];

endmodule

@@ hdl/mi3_checker.sv @@
module mi3_checker #(
    parameter int W = mi3_pkg::WORD_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input logic [W-1:0] inv_r0c0,
    input logic [W-1:0] inv_r1c1,
    input logic [W-1:0] inv_r2c2,
    input logic [W-1:0] det_value,
    input logic         singular
);

    localparam int LAT = W + 9;

    // Every accepted item produces a result after the fixed latency.
    a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item gave no result");

    // No result appears without an item accepted at the matching edge.
    a_lat_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result without an accepted item");

    // A singular result reports a zero determinant and a zero diagonal.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (det_value == '0 && inv_r0c0 == '0
                                && inv_r1c1 == '0 && inv_r2c2 == '0))
        else $error("singular result is not all zero");

    // The back end drains the queue every cycle, so it never fills.
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled up");

endmodule

bind matrix3x3_inverse_top mi3_checker #(.W(WORD_BITS)) u_mi3_checker (.*);
